// File: sv/ddok_pkg.sv
// shared types, constants and helper functions for the odometry kinematics block
package ddok_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_TIMES_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_WHEEL_GAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RADIUS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT        = 3'd5;

    // register reset values
    localparam logic [23:0] RST_RADIUS_TIMES_STEP   = 24'd1258;
    localparam logic [23:0] RST_ANGLE_PER_WHEEL_GAP = 24'd7853466;
    localparam logic [15:0] RST_TICKS_PER_SECOND    = 16'd1000;
    localparam logic [15:0] RST_HALF_TRACK          = 16'd44;
    localparam logic [15:0] RST_INVERSE_RADIUS      = 16'd3413;
    localparam logic [15:0] RST_TORQUE_LIMIT        = 16'd1280;

    // cordic
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int ITER_W           = 5;
    localparam int CW               = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // datapath widths
    localparam int A_W = 41;
    localparam int B_W = 34;
    localparam int P_W = A_W + B_W;
    localparam logic signed [B_W-1:0] TWO_PI_Q20 = 34'sd6588397;
    localparam logic signed [A_W-1:0] RATE_CLAMP = 41'sd274877906944;

    // multiply operations, in issue order
    typedef enum logic [3:0] {
        OP_DL   = 4'd0,
        OP_DR   = 4'd1,
        OP_TURN = 4'd2,
        OP_FV   = 4'd3,
        OP_RATE = 4'd4,
        OP_TV   = 4'd5,
        OP_YH   = 4'd6,
        OP_LJ   = 4'd7,
        OP_RJ   = 4'd8,
        OP_X    = 4'd9,
        OP_Y    = 4'd10
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              capture;
        logic              load;
        logic              mult;
        logic              mult_hi;
        logic              store;
        op_t               op;
        logic              cinit;
        logic              citer;
        logic [ITER_W-1:0] iter;
        logic              out_load;
    } ddok_cmd_t;

    // successor in the multiply sequence
    function automatic op_t next_op(input op_t op);
        op_t r;
        unique case (op)
            OP_DL:   r = OP_DR;
            OP_DR:   r = OP_TURN;
            OP_TURN: r = OP_FV;
            OP_FV:   r = OP_RATE;
            OP_RATE: r = OP_TV;
            OP_TV:   r = OP_YH;
            OP_YH:   r = OP_LJ;
            OP_LJ:   r = OP_RJ;
            OP_RJ:   r = OP_X;
            OP_X:    r = OP_Y;
            OP_Y:    r = OP_DL;
            default: r = OP_DL;
        endcase
        return r;
    endfunction

    // arctangent table in q.32 turns
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // saturate to a signed 16 bit value
    function automatic logic [15:0] sat16(input logic signed [P_W-1:0] v);
        logic [15:0] r;
        if (v > 75'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -75'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: sv/ddok_ctrl.sv
// sequencer for the shared multiplier, the cordic iterations and the result beat
module ddok_ctrl
    import ddok_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ddok_cmd_t cmd
);

    localparam int NITER = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NITER - 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b00000001,
        ST_LOAD    = 8'b00000010,
        ST_MULT    = 8'b00000100,
        ST_MULT_HI = 8'b00001000,
        ST_STORE   = 8'b00010000,
        ST_CINIT   = 8'b00100000,
        ST_CITER   = 8'b01000000,
        ST_OUT     = 8'b10000000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.iter     = iter_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    op_next     = OP_DL;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_MULT_HI;
            end
            ST_MULT_HI: begin
                cmd.mult_hi = 1'b1;
                state_next  = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                op_next   = next_op(op_reg);
                if (op_reg == OP_RJ) begin
                    state_next = ST_CINIT;
                end else if (op_reg == OP_Y) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_CINIT: begin
                cmd.cinit  = 1'b1;
                iter_next  = '0;
                state_next = ST_CITER;
            end
            ST_CITER: begin
                cmd.citer = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER) begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DL;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: sv/ddok_datapath.sv
// registers, shared multiplier, cordic rotator and result registers
module ddok_datapath
    import ddok_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ddok_cmd_t             cmd,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic signed [15:0]    s_left_rate,
    input  logic signed [15:0]    s_right_rate,
    input  logic signed [15:0]    s_forward_cmd,
    input  logic signed [15:0]    s_yaw_cmd,
    output logic signed [31:0]    m_pos_x,
    output logic signed [31:0]    m_pos_y,
    output logic [15:0]           m_heading,
    output logic signed [15:0]    m_forward_vel,
    output logic signed [15:0]    m_turn_vel,
    output logic signed [15:0]    m_left_joint_cmd,
    output logic signed [15:0]    m_right_joint_cmd,
    output logic [15:0]           m_max_force
);

    // low part of the first operand, multiplied in the first pass
    localparam int LO_W = 21;

    // configuration
    logic [23:0] rts_reg, apwg_reg;
    logic [15:0] tps_reg, half_track_reg, inv_radius_reg, torque_reg;

    // accumulated pose
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic [15:0]        angle_acc_reg;

    // per beat working values
    logic signed [15:0]   lrate_reg, rrate_reg, fwd_reg, yaw_reg;
    logic signed [32:0]   dl_reg, dr_reg;
    logic signed [57:0]   turn_reg;
    logic signed [A_W-1:0] rate_reg;
    logic signed [31:0]   yh_reg;
    logic [15:0]          fv_reg, tv_reg, lj_reg, rj_reg;
    logic signed [A_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [P_W-1:0] p_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;

    // derived values
    logic signed [33:0]    step, diff, lw, rw, cos_v, sin_v;
    logic signed [58:0]    turn_rnd;
    logic signed [A_W-1:0] turn_q16, turn_clamped;
    logic signed [A_W-1:0] a_sel;
    logic signed [B_W-1:0] b_sel;
    logic signed [LO_W+B_W:0]     pp_lo;
    logic signed [A_W-LO_W+B_W-1:0] pp_hi;
    logic signed [P_W-1:0] p_rnd8, p_rnd16, p_rnd38, p_rnd44;
    logic signed [32:0]    pos_sum;
    logic signed [31:0]    pos_sat;
    logic signed [31:0]    pos_base;
    logic signed [P_W-1:0] rate_clamped;
    logic [15:0]           angle_plus, cordic_angle;
    logic [15:0]           angle_step;
    logic signed [CW-1:0]  dx, dy, atan_v;

    assign step     = (34'(dl_reg) + 34'(dr_reg)) >>> 1;
    assign diff     = 34'(dl_reg) - 34'(dr_reg);
    assign lw       = 34'(fwd_reg) * 34'sd256 + 34'(yh_reg);
    assign rw       = 34'(fwd_reg) * 34'sd256 - 34'(yh_reg);
    assign turn_rnd = (59'(turn_reg) + 59'sd32768) >>> 16;
    assign turn_q16 = turn_rnd[A_W-1:0];
    assign cos_v    = flip_reg ? -cx_reg : cx_reg;
    assign sin_v    = flip_reg ? -cy_reg : cy_reg;

    // clamp the yaw rate term before it meets the tick rate
    always_comb begin
        if (turn_q16 > RATE_CLAMP) begin
            turn_clamped = RATE_CLAMP;
        end else if (turn_q16 < -RATE_CLAMP) begin
            turn_clamped = -RATE_CLAMP;
        end else begin
            turn_clamped = turn_q16;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (cmd.op)
            OP_DL: begin
                a_sel = A_W'(lrate_reg);
                b_sel = B_W'($signed({1'b0, rts_reg}));
            end
            OP_DR: begin
                a_sel = A_W'(rrate_reg);
                b_sel = B_W'($signed({1'b0, rts_reg}));
            end
            OP_TURN: begin
                a_sel = A_W'(diff);
                b_sel = B_W'($signed({1'b0, apwg_reg}));
            end
            OP_FV: begin
                a_sel = A_W'(step);
                b_sel = B_W'($signed({1'b0, tps_reg}));
            end
            OP_RATE: begin
                a_sel = turn_clamped;
                b_sel = B_W'($signed({1'b0, tps_reg}));
            end
            OP_TV: begin
                a_sel = rate_reg;
                b_sel = TWO_PI_Q20;
            end
            OP_YH: begin
                a_sel = A_W'(yaw_reg);
                b_sel = B_W'($signed({1'b0, half_track_reg}));
            end
            OP_LJ: begin
                a_sel = A_W'(lw);
                b_sel = B_W'($signed({1'b0, inv_radius_reg}));
            end
            OP_RJ: begin
                a_sel = A_W'(rw);
                b_sel = B_W'($signed({1'b0, inv_radius_reg}));
            end
            OP_X: begin
                a_sel = A_W'(cos_v);
                b_sel = B_W'(step);
            end
            OP_Y: begin
                a_sel = A_W'(sin_v);
                b_sel = B_W'(step);
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    // partial products: unsigned low part and signed high part of the first operand
    assign pp_lo = $signed({1'b0, a_reg[LO_W-1:0]}) * b_reg;
    assign pp_hi = $signed(a_reg[A_W-1:LO_W]) * b_reg;

    // rounded shifts of the product
    assign p_rnd8  = (p_reg + 75'sd128) >>> 8;
    assign p_rnd16 = (p_reg + 75'sd32768) >>> 16;
    assign p_rnd38 = (p_reg + (75'sd1 <<< 37)) >>> 38;
    assign p_rnd44 = (p_reg + (75'sd1 <<< 43)) >>> 44;

    // saturating pose update
    assign pos_base = (cmd.op == OP_X) ? x_acc_reg : y_acc_reg;
    assign pos_sum  = 33'(pos_base) + p_rnd38[32:0];
    always_comb begin
        if (pos_sum > 33'sd2147483647) begin
            pos_sat = 32'sh7FFFFFFF;
        end else if (pos_sum < -33'sd2147483648) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
    end

    always_comb begin
        if (p_reg > 75'(RATE_CLAMP)) begin
            rate_clamped = 75'(RATE_CLAMP);
        end else if (p_reg < -75'(RATE_CLAMP)) begin
            rate_clamped = -75'(RATE_CLAMP);
        end else begin
            rate_clamped = p_reg;
        end
    end

    assign angle_step = 16'((59'(turn_reg) + (59'sd1 <<< 31)) >>> 32);

    // cordic input folding and one rotation
    assign angle_plus   = angle_acc_reg + 16'h4000;
    assign cordic_angle = angle_plus[15] ? (angle_acc_reg ^ 16'h8000) : angle_acc_reg;
    assign dx     = cy_reg >>> cmd.iter;
    assign dy     = cx_reg >>> cmd.iter;
    assign atan_v = CW'($signed({1'b0, atan_turn(cmd.iter)}));

    // configuration and pose registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rts_reg        <= RST_RADIUS_TIMES_STEP;
            apwg_reg       <= RST_ANGLE_PER_WHEEL_GAP;
            tps_reg        <= RST_TICKS_PER_SECOND;
            half_track_reg <= RST_HALF_TRACK;
            inv_radius_reg <= RST_INVERSE_RADIUS;
            torque_reg     <= RST_TORQUE_LIMIT;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            angle_acc_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_RADIUS_TIMES_STEP:   rts_reg        <= cfg_wdata;
                    REG_ANGLE_PER_WHEEL_GAP: apwg_reg       <= cfg_wdata;
                    REG_TICKS_PER_SECOND:    tps_reg        <= cfg_wdata[15:0];
                    REG_HALF_TRACK:          half_track_reg <= cfg_wdata[15:0];
                    REG_INVERSE_RADIUS:      inv_radius_reg <= cfg_wdata[15:0];
                    REG_TORQUE_LIMIT:        torque_reg     <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.store && cmd.op == OP_X) begin
                x_acc_reg <= pos_sat;
            end
            if (cmd.store && cmd.op == OP_Y) begin
                y_acc_reg     <= pos_sat;
                angle_acc_reg <= angle_acc_reg + angle_step;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lrate_reg <= s_left_rate;
            rrate_reg <= s_right_rate;
            fwd_reg   <= s_forward_cmd;
            yaw_reg   <= s_yaw_cmd;
        end
        if (cmd.load) begin
            a_reg <= a_sel;
            b_reg <= b_sel;
        end
        // two pass multiply: low partial product, then add the shifted high one
        if (cmd.mult) begin
            p_reg <= P_W'(pp_lo);
        end else if (cmd.mult_hi) begin
            p_reg <= p_reg + (P_W'(pp_hi) <<< LO_W);
        end
        if (cmd.store) begin
            unique case (cmd.op)
                OP_DL:   dl_reg   <= p_rnd8[32:0];
                OP_DR:   dr_reg   <= p_rnd8[32:0];
                OP_TURN: turn_reg <= p_reg[57:0];
                OP_FV:   fv_reg   <= sat16(p_rnd16);
                OP_RATE: rate_reg <= rate_clamped[A_W-1:0];
                OP_TV:   tv_reg   <= sat16(p_rnd44);
                OP_YH:   yh_reg   <= p_reg[31:0];
                OP_LJ:   lj_reg   <= sat16(p_rnd16);
                OP_RJ:   rj_reg   <= sat16(p_rnd16);
                OP_X, OP_Y: ;
                default: ;
            endcase
        end
        if (cmd.cinit) begin
            flip_reg <= angle_plus[15];
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= CW'($signed(cordic_angle)) <<< 16;
        end
        if (cmd.citer) begin
            if (!cz_reg[CW-1]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.out_load) begin
            m_pos_x           <= x_acc_reg;
            m_pos_y           <= y_acc_reg;
            m_heading         <= angle_acc_reg;
            m_forward_vel     <= fv_reg;
            m_turn_vel        <= tv_reg;
            m_left_joint_cmd  <= lj_reg;
            m_right_joint_cmd <= rj_reg;
            m_max_force       <= torque_reg;
        end
    end

endmodule

// File: sv/diff_drive_odometry_kinematics.sv
// top level: differential drive odometry and wheel command kinematics
// one item at a time: eleven passes through the one shared multiplier (load,
//   low and high multiply, store) and the serial cordic finish before the
//   next input beat is accepted
// a finished result waits in the output register while the next beat is accepted
// reset (synchronous, active low) clears the pose and loads the register defaults
module diff_drive_odometry_kinematics
    import ddok_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_left_rate,
    input  logic signed [15:0]    s_right_rate,
    input  logic signed [15:0]    s_forward_cmd,
    input  logic signed [15:0]    s_yaw_cmd,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_pos_x,
    output logic signed [31:0]    m_pos_y,
    output logic [15:0]           m_heading,
    output logic signed [15:0]    m_forward_vel,
    output logic signed [15:0]    m_turn_vel,
    output logic signed [15:0]    m_left_joint_cmd,
    output logic signed [15:0]    m_right_joint_cmd,
    output logic [15:0]           m_max_force
);

    ddok_cmd_t cmd;

    // sequencer
    ddok_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // arithmetic
    ddok_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_left_rate       (s_left_rate),
        .s_right_rate      (s_right_rate),
        .s_forward_cmd     (s_forward_cmd),
        .s_yaw_cmd         (s_yaw_cmd),
        .m_pos_x           (m_pos_x),
        .m_pos_y           (m_pos_y),
        .m_heading         (m_heading),
        .m_forward_vel     (m_forward_vel),
        .m_turn_vel        (m_turn_vel),
        .m_left_joint_cmd  (m_left_joint_cmd),
        .m_right_joint_cmd (m_right_joint_cmd),
        .m_max_force       (m_max_force)
    );

endmodule

// File: sv/ddok_checker.sv
// port level checks for the odometry kinematics block, bound to the top level
module ddok_props (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic signed [31:0]    m_pos_x,
    input logic signed [31:0]    m_pos_y,
    input logic [15:0]           m_heading,
    input logic signed [15:0]    m_forward_vel,
    input logic signed [15:0]    m_turn_vel,
    input logic signed [15:0]    m_left_joint_cmd,
    input logic signed [15:0]    m_right_joint_cmd,
    input logic [15:0]           m_max_force
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y)
            && $stable(m_heading) && $stable(m_forward_vel) && $stable(m_turn_vel)
            && $stable(m_left_joint_cmd) && $stable(m_right_joint_cmd)
            && $stable(m_max_force))
        else $error("stalled result beat changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // one item at a time: busy right after an input beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result beat without work in progress");

endmodule

bind diff_drive_odometry_kinematics ddok_props u_ddok_props (.*);
